// File: rtl/core/swhs_pkg.sv
// ----------------------------------------------------------------------------
// swhs_pkg
// shared types, register indexes and constants of the single-wire sensor reader
// ----------------------------------------------------------------------------
package swhs_pkg;

    // stream word widths
    localparam int IN_W  = 8;
    localparam int OUT_W = 40;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKE_LOW         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESP_TIMEOUT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_LOW_TIMEOUT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_HIGH_TIMEOUT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_THRESHOLD    = 3'd5;

    // register reset values
    localparam logic [15:0] WAKE_LOW_RST         = 16'd3000;
    localparam logic [7:0]  RELEASE_RST          = 8'd25;
    localparam logic [7:0]  RESP_TIMEOUT_RST     = 8'd85;
    localparam logic [7:0]  BIT_LOW_TIMEOUT_RST  = 8'd56;
    localparam logic [7:0]  BIT_HIGH_TIMEOUT_RST = 8'd75;
    localparam logic [7:0]  ONE_THRESHOLD_RST    = 8'd40;

    // frame length in bits
    localparam int FRAME_BITS = 40;

    // line drive codes
    localparam logic [1:0] LINE_RELEASE = 2'd0;
    localparam logic [1:0] LINE_LOW     = 2'd1;
    localparam logic [1:0] LINE_HIGH    = 2'd2;

    // read status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_CSUM    = 2'd2;

    // configuration register set
    typedef struct packed {
        logic [15:0] wake_low_us;
        logic [7:0]  release_us;
        logic [7:0]  response_timeout_us;
        logic [7:0]  bit_low_timeout_us;
        logic [7:0]  bit_high_timeout_us;
        logic [7:0]  one_threshold_us;
    } swhs_cfg_t;

    // decoded frame
    typedef struct packed {
        logic [15:0] humidity;
        logic [15:0] temperature;
        logic        csum_ok;
    } swhs_frame_t;

    // one result word
    typedef struct packed {
        logic [1:0]        line_mode;
        logic              busy;
        logic              done;
        logic [1:0]        status;
        logic [15:0]       humidity_tenths;
        logic signed [15:0] temperature_tenths;
    } swhs_result_t;

endpackage

// File: rtl/core/single_wire_humidity_sensor_reader_top.sv
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader_top
// single-wire humidity and temperature sensor reader, one word per tick
//
//   channel  dir  handshake               payload
//   s_*      in   s_tvalid / s_tready     start request, sampled line level
//   m_*      out  m_tvalid / m_tready     line drive, busy, done, status, values
//   cfg_*    in   cfg_valid / cfg_ready   register index, write data
//
// one input word is taken every cycle while the output is not stalled; its result word passes
// through an input register and then a result register, which the step logic sets.
// a stalled output holds the result register and the input register; the input
// side keeps accepting until both are full. cfg_ready is always high.
// reset restores register defaults and returns the sequencer to idle at once.
// ----------------------------------------------------------------------------
module single_wire_humidity_sensor_reader_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // [0] start_read, [1] line_level, [7:2] zero
    input  logic [swhs_pkg::IN_W-1:0]      s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [1:0] line_mode, [2] busy_res, [3] done_res, [5:4] status,
    // [21:6] humidity_tenths, [37:22] temperature_tenths, [39:38] zero
    output logic [swhs_pkg::OUT_W-1:0]     m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [swhs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data
);
    import swhs_pkg::*;

    swhs_cfg_t    cfg;
    swhs_result_t result;

    logic in_valid_reg;
    logic start_reg;
    logic level_reg;
    logic out_valid_reg;
    logic advance;
    logic step_en;

    // pipeline flow
    assign advance  = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            start_reg <= s_tdata[0];
            level_reg <= s_tdata[1];
        end
    end

    // result word valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    swhs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    swhs_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step_en),
        .start_read (start_reg),
        .line_level (level_reg),
        .cfg        (cfg),
        .result     (result)
    );

    // output word packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, result.temperature_tenths, result.humidity_tenths,
                       result.status, result.done, result.busy, result.line_mode};

`ifndef ASSERT_OFF
    // a finished read is no longer busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[3]) |-> !m_tdata[2])
        else $error("done word still flags busy");

    // status is only reported with done
    a_status_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[5:4] != ST_OK)) |-> m_tdata[3])
        else $error("status set without done");

    // the line is only driven during a read
    a_drive_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] != LINE_RELEASE)) |-> m_tdata[2])
        else $error("line driven while idle");

    // a stalled result is not overwritten by the step logic
    a_no_step_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !step_en)
        else $error("step taken while result stalled");
`endif

endmodule

// File: rtl/core/swhs_cfg.sv
// ----------------------------------------------------------------------------
// swhs_cfg
// configuration register file with write channel
// ----------------------------------------------------------------------------
module swhs_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [swhs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data,
    output swhs_pkg::swhs_cfg_t            cfg
);
    import swhs_pkg::*;

    swhs_cfg_t cfg_reg;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register writes, indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wake_low_us         <= WAKE_LOW_RST;
            cfg_reg.release_us          <= RELEASE_RST;
            cfg_reg.response_timeout_us <= RESP_TIMEOUT_RST;
            cfg_reg.bit_low_timeout_us  <= BIT_LOW_TIMEOUT_RST;
            cfg_reg.bit_high_timeout_us <= BIT_HIGH_TIMEOUT_RST;
            cfg_reg.one_threshold_us    <= ONE_THRESHOLD_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WAKE_LOW:         cfg_reg.wake_low_us         <= cfg_data;
                CFG_RELEASE:          cfg_reg.release_us          <= cfg_data[7:0];
                CFG_RESP_TIMEOUT:     cfg_reg.response_timeout_us <= cfg_data[7:0];
                CFG_BIT_LOW_TIMEOUT:  cfg_reg.bit_low_timeout_us  <= cfg_data[7:0];
                CFG_BIT_HIGH_TIMEOUT: cfg_reg.bit_high_timeout_us <= cfg_data[7:0];
                CFG_ONE_THRESHOLD:    cfg_reg.one_threshold_us    <= cfg_data[7:0];
                default:              cfg_reg                     <= cfg_reg;
            endcase
        end
    end

endmodule

// File: rtl/core/swhs_decode.sv
// ----------------------------------------------------------------------------
// swhs_decode
// splits a 40-bit frame into humidity, signed temperature and checksum check
// ----------------------------------------------------------------------------
module swhs_decode (
    input  logic [39:0]           frame_word,
    output swhs_pkg::swhs_frame_t frame
);
    import swhs_pkg::*;

    logic [7:0]  b0, b1, b2, b3, b4;
    logic [15:0] mag;
    logic [7:0]  sum;

    assign b0 = frame_word[39:32];
    assign b1 = frame_word[31:24];
    assign b2 = frame_word[23:16];
    assign b3 = frame_word[15:8];
    assign b4 = frame_word[7:0];

    // sign-magnitude temperature to two's complement
    assign mag = {1'b0, b2[6:0], b3};
    assign frame.temperature = b2[7] ? (16'd0 - mag) : mag;
    assign frame.humidity    = {b0, b1};

    // additive checksum, modulo 256
    assign sum = b0 + b1 + b2 + b3;
    assign frame.csum_ok = (sum == b4);

endmodule

// File: rtl/core/swhs_fsm.sv
// ----------------------------------------------------------------------------
// swhs_fsm
// read sequencer: one tick step per enable, state and result register
// ----------------------------------------------------------------------------
module swhs_fsm (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step_en,
    input  logic                   start_read,
    input  logic                   line_level,
    input  swhs_pkg::swhs_cfg_t    cfg,
    output swhs_pkg::swhs_result_t result
);
    import swhs_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_WAKE      = 4'd1,
        PH_RELEASE   = 4'd2,
        PH_RESP_LOW  = 4'd3,
        PH_RESP_HIGH = 4'd4,
        PH_BIT_LOW   = 4'd5,
        PH_BIT_HIGH  = 4'd6
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic [15:0]  tick_count_reg, tick_count_next;
    logic [5:0]   bit_index_reg, bit_index_next;
    logic [39:0]  shift_data_reg, shift_data_next;
    logic [15:0]  humidity_reg, humidity_next;
    logic [15:0]  temperature_reg, temperature_next;
    swhs_result_t result_reg, result_next;

    logic         one_bit;
    logic [39:0]  frame_word;
    swhs_frame_t  frame;

    // bit decision and the frame as it stands after this bit
    assign one_bit    = tick_count_reg > {8'd0, cfg.one_threshold_us};
    assign frame_word = {shift_data_reg[38:0], one_bit};

    swhs_decode u_decode (
        .frame_word (frame_word),
        .frame      (frame)
    );

    // one tick of the read sequence
    always_comb
    begin
        phase_t      ph;
        logic [15:0] cnt;
        logic [7:0]  limit;
        logic        expect_level;
        logic [1:0]  mode;
        logic        done;
        logic [1:0]  status;
        logic [5:0]  idx_inc;

        ph               = phase_reg;
        cnt              = tick_count_reg;
        mode             = LINE_RELEASE;
        done             = 1'b0;
        status           = ST_OK;
        limit            = cfg.response_timeout_us;
        expect_level     = 1'b0;
        idx_inc          = bit_index_reg + 6'd1;
        bit_index_next   = bit_index_reg;
        shift_data_next  = shift_data_reg;
        humidity_next    = humidity_reg;
        temperature_next = temperature_reg;

        // start and zero-length drive phases fall through in the same tick
        if (ph == PH_IDLE && start_read)
        begin
            ph  = PH_WAKE;
            cnt = 16'd0;
        end
        if (ph == PH_WAKE && cnt >= cfg.wake_low_us)
        begin
            ph  = PH_RELEASE;
            cnt = 16'd0;
        end
        if (ph == PH_RELEASE && cnt >= {8'd0, cfg.release_us})
        begin
            ph  = PH_RESP_LOW;
            cnt = 16'd0;
        end

        // expected level and timeout of a measured phase
        unique case (ph)
            PH_RESP_HIGH:
            begin
                expect_level = 1'b1;
                limit        = cfg.response_timeout_us;
            end
            PH_BIT_LOW:
            begin
                expect_level = 1'b0;
                limit        = cfg.bit_low_timeout_us;
            end
            PH_BIT_HIGH:
            begin
                expect_level = 1'b1;
                limit        = cfg.bit_high_timeout_us;
            end
            default:
            begin
                expect_level = 1'b0;
                limit        = cfg.response_timeout_us;
            end
        endcase

        unique case (ph)
            PH_IDLE:
            begin
                mode = LINE_RELEASE;
            end
            PH_WAKE:
            begin
                mode = LINE_LOW;
                cnt  = cnt + 16'd1;
            end
            PH_RELEASE:
            begin
                mode = LINE_HIGH;
                cnt  = cnt + 16'd1;
            end
            PH_RESP_LOW, PH_RESP_HIGH, PH_BIT_LOW, PH_BIT_HIGH:
            begin
                if (line_level == expect_level)
                begin
                    // phase still running: count or time out
                    if (cnt > {8'd0, limit})
                    begin
                        ph     = PH_IDLE;
                        done   = 1'b1;
                        status = ST_TIMEOUT;
                    end
                    else
                    begin
                        cnt = cnt + 16'd1;
                    end
                end
                else if (ph == PH_BIT_HIGH)
                begin
                    // end of a data bit
                    shift_data_next = frame_word;
                    bit_index_next  = idx_inc;
                    if (idx_inc >= 6'(FRAME_BITS))
                    begin
                        ph               = PH_IDLE;
                        done             = 1'b1;
                        status           = frame.csum_ok ? ST_OK : ST_CSUM;
                        humidity_next    = frame.humidity;
                        temperature_next = frame.temperature;
                    end
                    else
                    begin
                        ph  = PH_BIT_LOW;
                        cnt = 16'd1;
                    end
                end
                else
                begin
                    // edge moves to the next phase, counting as its first tick
                    unique case (ph)
                        PH_RESP_LOW:
                        begin
                            ph = PH_RESP_HIGH;
                        end
                        PH_RESP_HIGH:
                        begin
                            ph              = PH_BIT_LOW;
                            bit_index_next  = 6'd0;
                            shift_data_next = 40'd0;
                        end
                        default:
                        begin
                            ph = PH_BIT_HIGH;
                        end
                    endcase
                    cnt = 16'd1;
                end
            end
            default:
            begin
                // undefined code behaves as idle
                ph   = PH_IDLE;
                mode = LINE_RELEASE;
            end
        endcase

        phase_next                     = ph;
        tick_count_next                = cnt;
        result_next.line_mode          = mode;
        result_next.busy               = (ph != PH_IDLE);
        result_next.done               = done;
        result_next.status             = status;
        result_next.humidity_tenths    = humidity_next;
        result_next.temperature_tenths = temperature_next;
    end

    // sequencer state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            tick_count_reg  <= 16'd0;
            bit_index_reg   <= 6'd0;
            shift_data_reg  <= 40'd0;
            humidity_reg    <= 16'd0;
            temperature_reg <= 16'd0;
            result_reg      <= '0;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            tick_count_reg  <= tick_count_next;
            bit_index_reg   <= bit_index_next;
            shift_data_reg  <= shift_data_next;
            humidity_reg    <= humidity_next;
            temperature_reg <= temperature_next;
            result_reg      <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// File: tb/single_wire_humidity_sensor_reader_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader_top_test
// self-checking bench for the single-wire humidity sensor reader
//
// every input word is one microsecond tick: a start request and the sampled
// line level. a sensor script plays wake, release, response and 40 data bits
// into the block, while a local model of the read sequencer predicts each
// result word. result words are checked in order against the model. runs go
// through reset values with a short wake time, all-zero and maximum timeout
// settings and random short timings, with clean frames, overlong phases, cut
// frames and glitches, under several sender and receiver stall mixes.
// ----------------------------------------------------------------------------
module single_wire_humidity_sensor_reader_top_test;

    import swhs_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_TICKS_PER_MIX = 80;

    // sequencer phases of the local model
    typedef enum logic [3:0] {
        RD_IDLE,
        RD_WAKE,
        RD_RELEASE,
        RD_RESP_LOW,
        RD_RESP_HIGH,
        RD_BIT_LOW,
        RD_BIT_HIGH
    } rd_phase_t;

    logic                 clk;
    logic                 rst_n;
    logic [IN_W-1:0]      s_tdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [OUT_W-1:0]     m_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    // model state and register copy
    swhs_cfg_t   rd_cfg;
    rd_phase_t   rd_phase;
    logic [15:0] rd_ticks;
    logic [5:0]  rd_bits;
    logic [39:0] rd_shift;
    logic [15:0] rd_hum;
    logic [15:0] rd_temp;

    // predicted result words, oldest first
    swhs_result_t tick_expect[$];
    // sensor side line levels, from the first sample on
    logic         line_plan[$];

    swhs_result_t want_res;
    swhs_result_t got_res;

    int unsigned err_count;
    int unsigned ticks_sent;
    int unsigned words_checked;
    int unsigned reads_ok;
    int unsigned reads_timeout;
    int unsigned reads_csum;
    int unsigned cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    single_wire_humidity_sensor_reader_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words still due", cycle_count,
                 tick_expect.size());
        $display("single_wire_humidity_sensor_reader_top_test: done, errors");
        $finish;
    end

    // receiver backpressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result word checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_res.line_mode          = m_tdata[1:0];
            got_res.busy               = m_tdata[2];
            got_res.done               = m_tdata[3];
            got_res.status             = m_tdata[5:4];
            got_res.humidity_tenths    = m_tdata[21:6];
            got_res.temperature_tenths = m_tdata[37:22];
            if (tick_expect.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected result word %0d: %h", words_checked, m_tdata);
            end
            else
            begin
                want_res = tick_expect.pop_front();
                if (got_res !== want_res)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                    begin
                        $display("word %0d want mode %0d busy %0b done %0b st %0d hum %0d temp %0d",
                                 words_checked, want_res.line_mode, want_res.busy,
                                 want_res.done, want_res.status, want_res.humidity_tenths,
                                 want_res.temperature_tenths);
                        $display("word %0d got  mode %0d busy %0b done %0b st %0d hum %0d temp %0d",
                                 words_checked, got_res.line_mode, got_res.busy,
                                 got_res.done, got_res.status, got_res.humidity_tenths,
                                 got_res.temperature_tenths);
                    end
                end
            end
            words_checked++;
        end
    end

    // return the model to its reset state
    function automatic void model_reset();
        rd_cfg.wake_low_us         = WAKE_LOW_RST;
        rd_cfg.release_us          = RELEASE_RST;
        rd_cfg.response_timeout_us = RESP_TIMEOUT_RST;
        rd_cfg.bit_low_timeout_us  = BIT_LOW_TIMEOUT_RST;
        rd_cfg.bit_high_timeout_us = BIT_HIGH_TIMEOUT_RST;
        rd_cfg.one_threshold_us    = ONE_THRESHOLD_RST;
        rd_phase = RD_IDLE;
        rd_ticks = '0;
        rd_bits  = '0;
        rd_shift = '0;
        rd_hum   = '0;
        rd_temp  = '0;
    endfunction

    // advance the sequencer model by one tick and form its result word
    function automatic swhs_result_t model_tick(input logic start, input logic lvl);
        swhs_result_t r;
        logic         want_lvl;
        logic         bit_val;
        logic [7:0]   lim;
        logic [7:0]   b0, b1, b2, b3, b4;
        logic [15:0]  mag;
        r = '0;
        r.line_mode = LINE_RELEASE;
        r.status    = ST_OK;
        if (rd_phase == RD_IDLE && start)
        begin
            rd_phase = RD_WAKE;
            rd_ticks = '0;
        end
        // zero length drive phases fall through in the same tick
        if (rd_phase == RD_WAKE && rd_ticks >= rd_cfg.wake_low_us)
        begin
            rd_phase = RD_RELEASE;
            rd_ticks = '0;
        end
        if (rd_phase == RD_RELEASE && rd_ticks >= {8'd0, rd_cfg.release_us})
        begin
            rd_phase = RD_RESP_LOW;
            rd_ticks = '0;
        end
        case (rd_phase)
            RD_IDLE: ;
            RD_WAKE:
            begin
                r.line_mode = LINE_LOW;
                rd_ticks++;
            end
            RD_RELEASE:
            begin
                r.line_mode = LINE_HIGH;
                rd_ticks++;
            end
            default:
            begin
                want_lvl = (rd_phase == RD_RESP_HIGH || rd_phase == RD_BIT_HIGH);
                if (rd_phase == RD_BIT_LOW)
                    lim = rd_cfg.bit_low_timeout_us;
                else if (rd_phase == RD_BIT_HIGH)
                    lim = rd_cfg.bit_high_timeout_us;
                else
                    lim = rd_cfg.response_timeout_us;
                if (lvl == want_lvl)
                begin
                    if (rd_ticks > {8'd0, lim})
                    begin
                        rd_phase = RD_IDLE;
                        r.done   = 1'b1;
                        r.status = ST_TIMEOUT;
                        reads_timeout++;
                    end
                    else
                        rd_ticks++;
                end
                else if (rd_phase == RD_BIT_HIGH)
                begin
                    // falling edge ends a bit; long high means one
                    bit_val  = (rd_ticks > {8'd0, rd_cfg.one_threshold_us});
                    rd_shift = {rd_shift[38:0], bit_val};
                    rd_bits++;
                    if (rd_bits >= FRAME_BITS)
                    begin
                        b0 = rd_shift[39:32];
                        b1 = rd_shift[31:24];
                        b2 = rd_shift[23:16];
                        b3 = rd_shift[15:8];
                        b4 = rd_shift[7:0];
                        mag     = {1'b0, b2[6:0], b3};
                        rd_hum  = {b0, b1};
                        rd_temp = b2[7] ? (16'd0 - mag) : mag;
                        rd_phase = RD_IDLE;
                        r.done   = 1'b1;
                        if (b4 == 8'(b0 + b1 + b2 + b3))
                        begin
                            r.status = ST_OK;
                            reads_ok++;
                        end
                        else
                        begin
                            r.status = ST_CSUM;
                            reads_csum++;
                        end
                    end
                    else
                    begin
                        rd_phase = RD_BIT_LOW;
                        rd_ticks = 16'd1;
                    end
                end
                else
                begin
                    // level change opens the next phase and counts as its first tick
                    if (rd_phase == RD_RESP_HIGH)
                    begin
                        rd_bits  = '0;
                        rd_shift = '0;
                    end
                    rd_phase = rd_phase_t'(rd_phase + 1);
                    rd_ticks = 16'd1;
                end
            end
        endcase
        r.busy               = (rd_phase != RD_IDLE);
        r.humidity_tenths    = rd_hum;
        r.temperature_tenths = rd_temp;
        return r;
    endfunction

    // send one tick word, with random sender gaps
    task automatic drive_tick(input logic start, input logic lvl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, lvl, start};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tick_expect.push_back(model_tick(start, lvl));
        ticks_sent++;
    endtask

    // hold the sender until every predicted word has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tick_expect.size() != 0)
            @(posedge clk);
    endtask

    // write all six registers, block idle
    task automatic load_settings(input swhs_cfg_t c);
        logic [CFG_IDX_W-1:0] idx [6];
        logic [15:0]          val [6];
        idx[0] = CFG_WAKE_LOW;         val[0] = c.wake_low_us;
        idx[1] = CFG_RELEASE;          val[1] = {8'd0, c.release_us};
        idx[2] = CFG_RESP_TIMEOUT;     val[2] = {8'd0, c.response_timeout_us};
        idx[3] = CFG_BIT_LOW_TIMEOUT;  val[3] = {8'd0, c.bit_low_timeout_us};
        idx[4] = CFG_BIT_HIGH_TIMEOUT; val[4] = {8'd0, c.bit_high_timeout_us};
        idx[5] = CFG_ONE_THRESHOLD;    val[5] = {8'd0, c.one_threshold_us};
        for (int i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        rd_cfg = c;
    endtask

    // start requests while a read runs, to be ignored
    function automatic logic busy_start();
        return (rd_phase != RD_IDLE) && ($urandom_range(3) == 0);
    endfunction

    // phase length, mostly short, sometimes the longest allowed
    function automatic int pick_len(input int lo, input int hi);
        if (hi < lo)
            hi = lo;
        if ($urandom_range(3) == 0)
            return hi;
        return lo + $urandom_range(((hi - lo) < 2) ? (hi - lo) : 2);
    endfunction

    function automatic void push_phase(input logic lvl, input int n);
        for (int i = 0; i < n; i++)
            line_plan.push_back(lvl);
    endfunction

    // random frame, with sign and checksum corner cases mixed in
    function automatic logic [39:0] make_frame();
        logic [7:0] b0, b1, b2, b3, csum;
        b0 = 8'($urandom);
        b1 = 8'($urandom);
        b2 = 8'($urandom);
        b3 = 8'($urandom);
        case ($urandom_range(7))
            0:
            begin
                // negative zero
                b2 = 8'h80;
                b3 = 8'h00;
            end
            1:
            begin
                b2 = 8'hFF;
                b3 = 8'hFF;
            end
            2:
            begin
                b2 = 8'h7F;
                b3 = 8'hFF;
            end
            3:
            begin
                b0 = 8'h00;
                b1 = 8'h00;
            end
            4:
            begin
                b0 = 8'hFF;
                b1 = 8'hFF;
            end
            default: ;
        endcase
        csum = b0 + b1 + b2 + b3;
        if ($urandom_range(4) == 0)
            csum = csum ^ 8'($urandom_range(1, 255));
        return {b0, b1, b2, b3, csum};
    endfunction

    // sensor script for one frame; an overlong phase cuts it short with a timeout
    function automatic void build_plan(input logic [39:0] frame, input int cut_phase);
        int lim;
        int n;
        line_plan.delete();
        // phase 0/1 is the response, then low and high of each bit, msb first
        for (int k = 0; k < 82; k++)
        begin
            if (k < 2)
                lim = rd_cfg.response_timeout_us;
            else if (k % 2 == 0)
                lim = rd_cfg.bit_low_timeout_us;
            else
                lim = rd_cfg.bit_high_timeout_us;
            if (k == cut_phase)
            begin
                push_phase(1'(k % 2), lim + 2);
                return;
            end
            if (k >= 2 && k % 2 == 1)
            begin
                if (frame[39 - (k - 2) / 2])
                    n = pick_len(rd_cfg.one_threshold_us + 1, lim + 1);
                else
                    n = pick_len(1, (rd_cfg.one_threshold_us < lim + 1) ?
                                    rd_cfg.one_threshold_us : lim + 1);
            end
            else
                n = pick_len(1, lim + 1);
            push_phase(1'(k % 2), n);
        end
        // falling edge closing the last bit
        push_phase(1'b0, 1);
    endfunction

    // feed a constant low line until the model says the read is over
    task automatic finish_read();
        while (rd_phase != RD_IDLE)
            drive_tick(1'b0, 1'b0);
    endtask

    // start a read and play the sensor script into it
    task automatic play_read();
        int drive_len;
        int half;
        drive_len = int'(rd_cfg.wake_low_us) + int'(rd_cfg.release_us);
        half = line_plan.size() / 2;
        // with no drive time the start tick already carries the first sample
        if (drive_len == 0 && line_plan.size() > 0)
            drive_tick(1'b1, line_plan.pop_front());
        else
            drive_tick(1'b1, 1'($urandom_range(1)));
        for (int i = 1; i < drive_len; i++)
            drive_tick(busy_start(), 1'($urandom_range(1)));
        while (line_plan.size() > 0)
        begin
            // occasional pause mid-read until the output side has caught up
            if (line_plan.size() == half && $urandom_range(15) == 0)
                wait_drained();
            drive_tick(busy_start(), line_plan.pop_front());
        end
        finish_read();
    endtask

    // reset register values with a short wake time: a bit at the threshold,
    // a bit just above it, then a bit low phase that runs into its timeout
    task automatic test_reset_defaults();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cfg_valid <= 1'b1;
        cfg_index <= CFG_WAKE_LOW;
        cfg_data  <= 16'd2;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        rd_cfg.wake_low_us = 16'd2;
        drive_tick(1'b0, 1'b0);
        drive_tick(1'b0, 1'b1);
        line_plan.delete();
        push_phase(1'b0, 1);
        push_phase(1'b1, 1);
        push_phase(1'b0, 1);
        push_phase(1'b1, int'(ONE_THRESHOLD_RST));
        push_phase(1'b0, 1);
        push_phase(1'b1, int'(ONE_THRESHOLD_RST) + 1);
        play_read();
        wait_drained();
    endtask

    // all registers zero: no drive time, one-tick phases, immediate timeouts
    task automatic test_zero_settings();
        swhs_cfg_t c;
        c = '0;
        send_idle_pct  = 25;
        recv_stall_pct = 25;
        wait_drained();
        load_settings(c);
        // start samples the line at once; second low tick times out
        drive_tick(1'b1, 1'b0);
        drive_tick(1'b1, 1'b0);
        // high on the start tick skips the response low phase
        drive_tick(1'b1, 1'b1);
        drive_tick(1'b0, 1'b0);
        drive_tick(1'b1, 1'b1);
        drive_tick(1'b0, 1'b1);
        drive_tick(1'b0, 1'b0);
        drive_tick(1'b0, 1'b1);
        // response low then high too long
        drive_tick(1'b1, 1'b0);
        drive_tick(1'b0, 1'b1);
        drive_tick(1'b0, 1'b1);
        finish_read();
        wait_drained();
    endtask

    // timeouts and threshold at their maximum, one bit high right at the timeout
    task automatic test_longest_settings();
        swhs_cfg_t c;
        c.wake_low_us         = 16'd2;
        c.release_us          = 8'd2;
        c.response_timeout_us = 8'hFF;
        c.bit_low_timeout_us  = 8'hFF;
        c.bit_high_timeout_us = 8'hFF;
        c.one_threshold_us    = 8'hFF;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_drained();
        load_settings(c);
        line_plan.delete();
        push_phase(1'b0, 1);
        push_phase(1'b1, 1);
        // first bit high for 256 ticks: no timeout, decodes as one
        push_phase(1'b0, 1);
        push_phase(1'b1, 256);
        for (int i = 0; i < FRAME_BITS - 1; i++)
        begin
            push_phase(1'b0, 1);
            push_phase(1'b1, 1);
        end
        push_phase(1'b0, 1);
        play_read();
        wait_drained();
    endtask

    // random short timings under each stall mix
    task automatic test_random_reads();
        int          idle_mix [4];
        int          stall_mix [4];
        swhs_cfg_t   c;
        int unsigned base;
        int          kind;
        int          pos;
        idle_mix[0] = 0;   stall_mix[0] = 0;
        idle_mix[1] = 56;  stall_mix[1] = 0;
        idle_mix[2] = 0;   stall_mix[2] = 56;
        idle_mix[3] = 25;  stall_mix[3] = 25;
        for (int p = 0; p < 4; p++)
        begin
            c.wake_low_us         = 16'($urandom_range(3));
            c.release_us          = 8'($urandom_range(3));
            c.response_timeout_us = 8'($urandom_range(1, 4));
            c.bit_low_timeout_us  = 8'($urandom_range(3));
            c.bit_high_timeout_us = 8'($urandom_range(1, 5));
            c.one_threshold_us    = 8'($urandom_range(1, c.bit_high_timeout_us));
            wait_drained();
            load_settings(c);
            send_idle_pct  = idle_mix[p];
            recv_stall_pct = stall_mix[p];
            base = ticks_sent;
            while (ticks_sent - base < RANDOM_TICKS_PER_MIX)
            begin
                kind = $urandom_range(9);
                build_plan(make_frame(), (kind == 7) ? int'($urandom_range(81)) : -1);
                // cut frame
                if (kind == 8)
                    repeat ($urandom_range(1, line_plan.size() - 1))
                        void'(line_plan.pop_back());
                // glitches on the line
                if (kind == 9)
                    repeat ($urandom_range(1, 4))
                    begin
                        pos = $urandom_range(line_plan.size() - 1);
                        line_plan[pos] = !line_plan[pos];
                    end
                play_read();
            end
        end
        wait_drained();
    endtask

    // main sequence
    initial
    begin
        rst_n          = 1'b0;
        s_tdata        = '0;
        s_tvalid       = 1'b0;
        m_tready       = 1'b1;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        err_count      = 0;
        ticks_sent     = 0;
        words_checked  = 0;
        reads_ok       = 0;
        reads_timeout  = 0;
        reads_csum     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        model_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_zero_settings();
        test_longest_settings();
        test_random_reads();

        wait_drained();
        repeat (4) @(posedge clk);
        $display("ticks sent %0d, result words checked %0d, mismatches %0d",
                 ticks_sent, words_checked, err_count);
        $display("reads ended: %0d good, %0d timed out, %0d bad checksum",
                 reads_ok, reads_timeout, reads_csum);
        if (err_count == 0)
            $display("single_wire_humidity_sensor_reader_top_test: done, clean");
        else
            $display("single_wire_humidity_sensor_reader_top_test: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/swhs_pkg.sv
rtl/core/swhs_cfg.sv
rtl/core/swhs_decode.sv
rtl/core/swhs_fsm.sv
rtl/core/single_wire_humidity_sensor_reader_top.sv
tb/single_wire_humidity_sensor_reader_top_test.sv
